// ===== src/sct_pkg.sv =====
// Shared types and constants for the character-set trim block.
package sct_pkg;

  localparam int unsigned HELD_DEPTH_DEF = 63;
  localparam int unsigned TRIM_SLOTS     = 8;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned LEN_W          = 16;

  localparam logic [CFG_DATA_W-1:0] TRIM_CHARS_RST = 64'h0000_0000_200D_0A09;
  localparam logic [3:0]            TRIM_COUNT_RST = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TRIM_CHARS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT = 1'b1;

  // What the front decided about one accepted word.
  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,  // character outside the trim set
    CMD_SET  = 2'd1,  // trim set member
    CMD_END  = 2'd2   // end of string
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] ch;
  } cmd_t;

endpackage

// ===== src/stream_char_set_trim_core.sv =====
// Top level of the streaming character-set trim block.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | in_char_i, end_marker_i
//  out     | source    | out_valid_o/out_stall_i | out_char_o, is_terminator_o,
//          |           |                       | kept_length_o, overflow_o, last_of_run_o
//  cfg     | sink      | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// Flow: the front takes one word per cycle into a two-entry queue while it is not
//   full. The back retires a set char without waiting on the output, a plain char
//   or end word when the output register can load. A char behind a held run waits
//   for flush start, a registered held-run read and a load per byte, then the char.
// Reset: async, active low; clears control state and the output register.
//   The held-run buffer is not cleared; no clearing pass.
// Stalls: the output register loads while the old word is taken, so the back
//   keeps moving under continuous flow; the queue lets input run ahead.
module stream_char_set_trim_core #(
  parameter int unsigned HELD_DEPTH = sct_pkg::HELD_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_char_i,
  input  logic                           end_marker_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_char_o,
  output logic                           is_terminator_o,
  output logic [sct_pkg::LEN_W-1:0]      kept_length_o,
  output logic                           overflow_o,
  output logic                           last_of_run_o,
  input  logic                           cfg_we_i,
  input  logic [sct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sct_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sct_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, head_cmd;

  // classify and accept
  sct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_char_i    (in_char_i),
    .end_marker_i (end_marker_i),
    .in_stall_o   (in_stall_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  // decouples input acceptance from run flushes
  sct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  // hold, flush and emit
  sct_back #(
    .HeldDepth (HELD_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (head_cmd),
    .q_pop_o         (q_pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_char_o      (out_char_o),
    .is_terminator_o (is_terminator_o),
    .kept_length_o   (kept_length_o),
    .overflow_o      (overflow_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ===== src/sct_front.sv =====
// Front end: config registers, input handshake and trim set classification.
module sct_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [7:0]                     in_char_i,
  input  logic                           end_marker_i,
  output logic                           in_stall_o,
  input  logic                           cfg_we_i,
  input  logic [sct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sct_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output sct_pkg::cmd_t                  q_cmd_o
);
  import sct_pkg::*;

  logic [CFG_DATA_W-1:0] trim_chars_q;
  logic [3:0]            trim_count_q;
  logic                  hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_chars_q <= TRIM_CHARS_RST;
      trim_count_q <= TRIM_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRIM_CHARS: trim_chars_q <= cfg_wdata_i;
        REG_TRIM_COUNT: trim_count_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // counts above eight enable every slot
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < TRIM_SLOTS; i++) begin
      if ((4'(i) < trim_count_q) && (trim_chars_q[8*i +: 8] == in_char_i)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    q_cmd_o.ch = in_char_i;
    if (end_marker_i) begin
      q_cmd_o.kind = CMD_END;
    end else if (hit) begin
      q_cmd_o.kind = CMD_SET;
    end else begin
      q_cmd_o.kind = CMD_CHAR;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

endmodule

// ===== src/sct_queue.sv =====
// Short command queue between front and back.
module sct_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sct_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output sct_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import sct_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/sct_back.sv =====
// Back end: held-run buffer, run flush sequencer and output register.
module sct_back #(
  parameter int unsigned HeldDepth = sct_pkg::HELD_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  sct_pkg::cmd_t             q_cmd_i,
  output logic                      q_pop_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [7:0]                out_char_o,
  output logic                      is_terminator_o,
  output logic [sct_pkg::LEN_W-1:0] kept_length_o,
  output logic                      overflow_o,
  output logic                      last_of_run_o
);
  import sct_pkg::*;

  localparam int unsigned CntW  = $clog2(HeldDepth + 1);
  localparam int unsigned AddrW = (HeldDepth > 1) ? $clog2(HeldDepth) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(HeldDepth);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'b001,
    ST_FLUSH_RD = 3'b010,
    ST_FLUSH_WR = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] held_cnt_q, held_cnt_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            seen_q, seen_d;
  logic [LEN_W-1:0] kept_q, kept_d;
  logic            ovf_q, ovf_d;

  logic [7:0]      mem_q [HeldDepth];
  logic [7:0]      rd_data_q;
  logic            mem_we;

  logic            load_ok, load;
  logic [7:0]      ld_char;
  logic            ld_term, ld_last;
  logic [LEN_W-1:0] ld_len;
  logic [LEN_W-1:0] kept_inc;

  assign load_ok  = ~out_valid_o | ~out_stall_i;
  assign kept_inc = (kept_q == '1) ? kept_q : kept_q + LEN_W'(1);

  always_comb begin
    state_d    = state_q;
    held_cnt_d = held_cnt_q;
    rd_idx_d   = rd_idx_q;
    seen_d     = seen_q;
    kept_d     = kept_q;
    ovf_d      = ovf_q;
    mem_we     = 1'b0;
    q_pop_o    = 1'b0;
    load       = 1'b0;
    ld_char    = '0;
    ld_term    = 1'b0;
    ld_len     = '0;
    ld_last    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_cmd_i.kind)
            CMD_END: begin
              if (load_ok) begin
                load       = 1'b1;
                ld_term    = 1'b1;
                ld_len     = kept_q;
                ld_last    = 1'b1;
                q_pop_o    = 1'b1;
                held_cnt_d = '0;
                seen_d     = 1'b0;
                kept_d     = '0;
              end
            end
            CMD_SET: begin
              q_pop_o = 1'b1;
              if (seen_q) begin
                if (held_cnt_q < CntMax) begin
                  mem_we     = 1'b1;
                  held_cnt_d = held_cnt_q + CntW'(1);
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            CMD_CHAR: begin
              if (held_cnt_q != '0) begin
                // flush the held run first, the char stays at the queue head
                rd_idx_d = '0;
                state_d  = ST_FLUSH_RD;
              end else if (load_ok) begin
                load    = 1'b1;
                ld_char = q_cmd_i.ch;
                ld_last = 1'b1;
                q_pop_o = 1'b1;
                seen_d  = 1'b1;
                kept_d  = kept_inc;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH_RD: state_d = ST_FLUSH_WR;
      ST_FLUSH_WR: begin
        if (load_ok) begin
          load     = 1'b1;
          ld_char  = rd_data_q;
          kept_d   = kept_inc;
          rd_idx_d = rd_idx_q + CntW'(1);
          if (rd_idx_q + CntW'(1) == held_cnt_q) begin
            held_cnt_d = '0;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_FLUSH_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      held_cnt_q <= '0;
      rd_idx_q   <= '0;
      seen_q     <= 1'b0;
      kept_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      held_cnt_q <= held_cnt_d;
      rd_idx_q   <= rd_idx_d;
      seen_q     <= seen_d;
      kept_q     <= kept_d;
      ovf_q      <= ovf_d;
    end
  end

  // held-run memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[held_cnt_q[AddrW-1:0]] <= q_cmd_i.ch;
    end
    rd_data_q <= mem_q[rd_idx_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o     <= 1'b0;
      out_char_o      <= '0;
      is_terminator_o <= 1'b0;
      kept_length_o   <= '0;
      overflow_o      <= 1'b0;
      last_of_run_o   <= 1'b0;
    end else if (load) begin
      out_valid_o     <= 1'b1;
      out_char_o      <= ld_char;
      is_terminator_o <= ld_term;
      kept_length_o   <= ld_len;
      overflow_o      <= ovf_q;
      last_of_run_o   <= ld_last;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

endmodule

// ===== src/sct_checker.sv =====
// Port-level checks for the trim block, bound onto the top level.
module sct_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [7:0]                     in_char_i,
  input logic                           end_marker_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [7:0]                     out_char_o,
  input logic                           is_terminator_o,
  input logic [sct_pkg::LEN_W-1:0]      kept_length_o,
  input logic                           overflow_o,
  input logic                           last_of_run_o,
  input logic                           cfg_we_i,
  input logic [sct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [sct_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_char_o) && $stable(kept_length_o)
      && $stable(is_terminator_o) && $stable(last_of_run_o))
    else $error("stalled output word changed");

  a_term_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_terminator_o |-> (out_char_o == 8'd0) && last_of_run_o)
    else $error("terminator must carry a zero char and close its run");

  a_char_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_terminator_o |-> (kept_length_o == '0))
    else $error("char word carries a length");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(overflow_o))
    else $error("overflow flag cleared without reset");

endmodule

bind stream_char_set_trim_core sct_checker u_sct_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stream_char_set_trim_core against a trim predictor.
module testbench;
  import sct_pkg::*;

  // Bench knobs
  localparam int unsigned HELD_MAX    = HELD_DEPTH_DEF;
  localparam int unsigned IDLE_PCT    = 23;     // idle / stall odds per cycle, in percent
  localparam int unsigned QUIET_LIMIT = 4000;   // cycles with no traffic before giving up
  localparam int unsigned SETTLE      = 2 * HELD_DEPTH_DEF + 8;  // worst flush plus queue
  localparam int unsigned RAND_WORDS  = 10;     // random words per config phase

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_B   = 8'h62;

  // One input word and one output word
  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } word_t;

  typedef struct {
    logic [7:0]       ch;
    logic             term;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             last;
  } res_t;

  // DUT hookup
  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_char    = '0;
  logic                  end_marker = 1'b0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [7:0]            out_char;
  logic                  is_term;
  logic [LEN_W-1:0]      kept_len_o;
  logic                  ovf_o;
  logic                  last_o;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  stream_char_set_trim_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_char_i      (in_char),
    .end_marker_i   (end_marker),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_char_o     (out_char),
    .is_terminator_o(is_term),
    .kept_length_o  (kept_len_o),
    .overflow_o     (ovf_o),
    .last_of_run_o  (last_o),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #4 clk_i = ~clk_i;

  // Trim predictor: own copy of the registers and the string state
  logic [CFG_DATA_W-1:0] set_bytes = TRIM_CHARS_RST;
  logic [3:0]            set_count = TRIM_COUNT_RST;
  logic [7:0]            held_buf [HELD_MAX];
  int unsigned           held_len     = 0;
  bit                    seen_content = 1'b0;
  logic [LEN_W-1:0]      kept_total   = '0;
  bit                    ovf_sticky   = 1'b0;

  word_t pending[$];       // words waiting for the driver
  res_t  expected_out[$];  // trimmed output still owed by the DUT
  word_t cur_word;
  res_t  want_res;
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps     = 1'b0;  // both sides run flat out while set

  // Set membership; a count above eight still means eight slots
  function automatic bit is_trim_char(logic [7:0] c);
    int unsigned n;
    n = (set_count > 8) ? 8 : set_count;
    for (int unsigned i = 0; i < n; i++)
      if (set_bytes[8*i +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void count_kept();
    if (kept_total != {LEN_W{1'b1}}) kept_total++;
  endfunction

  // Expected output for one accepted word
  task automatic predict_trim(word_t w);
    if (w.eos) begin
      expected_out.push_back('{8'h00, 1'b1, kept_total, ovf_sticky, 1'b1});
      held_len     = 0;
      seen_content = 1'b0;
      kept_total   = '0;
    end else if (is_trim_char(w.ch)) begin
      // leading set chars vanish; trailing ones wait in the held run
      if (seen_content) begin
        if (held_len < HELD_MAX) begin
          held_buf[held_len] = w.ch;
          held_len++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end
    end else begin
      // a plain char releases the held run ahead of itself
      for (int unsigned i = 0; i < held_len; i++) begin
        expected_out.push_back('{held_buf[i], 1'b0, '0, ovf_sticky, 1'b0});
        count_kept();
      end
      held_len     = 0;
      seen_content = 1'b1;
      expected_out.push_back('{w.ch, 1'b0, '0, ovf_sticky, 1'b1});
      count_kept();
    end
  endtask

  // Driver: feeds pending words, holds a stalled word steady
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_char    <= '0;
      end_marker <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_trim(cur_word);
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          cur_word = pending.pop_front();
          in_valid   <= 1'b1;
          in_char    <= cur_word.ch;
          end_marker <= cur_word.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Monitor: random back-pressure, every taken word checked in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual char %0h term %0b len %0d",
                   $time, out_char, is_term, kept_len_o);
        end else begin
          want_res = expected_out.pop_front();
          check_field("out_char", want_res.ch, out_char);
          check_field("is_terminator", want_res.term, is_term);
          check_field("kept_length", want_res.len, kept_len_o);
          check_field("overflow", want_res.ovf, ovf_o);
          check_field("last_of_run", want_res.last, last_o);
        end
      end
      out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: only quiet cycles count toward the limit
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write; the predictor copy follows at the same edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_TRIM_CHARS) set_bytes = val;
    else                       set_count = val[3:0];
  endtask

  // Wait until everything sent came back, then let the core go quiet
  task automatic drain();
    while (pending.size() != 0 || in_valid || expected_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic push_word(logic [7:0] c, logic eos);
    pending.push_back('{c, eos});
  endtask

  function automatic logic [7:0] trim_pick();
    int unsigned n;
    n = (set_count > 8) ? 8 : set_count;
    if (n == 0) return 8'($urandom_range(255));
    return set_bytes[8*$urandom_range(n-1) +: 8];
  endfunction

  function automatic logic [7:0] plain_pick();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_trim_char(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  // Well-formed string: set chars around content, plain chars at both content ends
  task automatic push_string(int unsigned lead, int unsigned body, int unsigned trail);
    repeat (lead) push_word(trim_pick(), 1'b0);
    for (int unsigned i = 0; i < body; i++) begin
      if (i == 0 || i == body - 1 || $urandom_range(9) >= 3) push_word(plain_pick(), 1'b0);
      else                                                    push_word(trim_pick(), 1'b0);
    end
    repeat (trail) push_word(trim_pick(), 1'b0);
    push_word(8'($urandom_range(255)), 1'b1);
  endtask

  // Mostly clean strings, some long inner runs, some noise and cut-off strings
  task automatic random_words(int unsigned n);
    int unsigned target;
    int unsigned roll;
    target = pending.size() + n;
    while (pending.size() < target) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        push_word(8'($urandom_range(255)), $urandom_range(3) == 0);
      end else if (roll < 18) begin
        push_word(plain_pick(), 1'b0);
        repeat ($urandom_range(30, HELD_MAX)) push_word(trim_pick(), 1'b0);
        push_word(plain_pick(), 1'b0);
        push_string(0, 1, $urandom_range(HELD_MAX));
      end else begin
        push_string($urandom_range(4), $urandom_range(1, 12), $urandom_range(6));
      end
    end
    push_word(8'($urandom_range(255)), 1'b1);  // close whatever string was open
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset set (tab, LF, CR, space): empty string, then trims on both sides
    push_word(8'h00, 1'b1);
    push_word(CH_TAB, 1'b0);
    push_word(CH_SP, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(CH_A, 1'b0);
    push_word(CH_SP, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(CH_B, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(CH_CR, 1'b0);
    push_word(8'hFF, 1'b1);
    // zero and all-ones bytes are plain under the reset set
    push_word(8'h00, 1'b0);
    push_word(CH_SP, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(CH_TAB, 1'b0);
    push_word(8'h00, 1'b1);
    // set chars only: nothing kept
    push_word(CH_SP, 1'b0);
    push_word(CH_LF, 1'b0);
    push_word(8'h00, 1'b1);
    drain();
    random_words(RAND_WORDS);
    drain();

    // Empty set: every byte is kept
    write_reg(REG_TRIM_COUNT, '0);
    @(negedge clk_i);
    push_word(CH_SP, 1'b0);
    push_word(CH_A, 1'b0);
    push_word(CH_TAB, 1'b0);
    push_word(8'h00, 1'b1);
    random_words(RAND_WORDS);
    drain();

    // All-ones bytes, full count; run this phase with no gaps at all
    write_reg(REG_TRIM_CHARS, '1);
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(TRIM_SLOTS));
    @(negedge clk_i);
    no_gaps = 1'b1;
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b1);
    random_words(RAND_WORDS);
    drain();
    no_gaps = 1'b0;

    // Count above eight clamps; zero byte becomes the only member
    write_reg(REG_TRIM_CHARS, '0);
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(4'hF));
    @(negedge clk_i);
    push_word(8'h00, 1'b0);
    push_word(CH_A, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(CH_B, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b1);
    random_words(RAND_WORDS);
    drain();

    // Random set, partial count: upper slots must not match
    write_reg(REG_TRIM_CHARS, {$urandom, $urandom});
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(3));
    @(negedge clk_i);
    push_word(plain_pick(), 1'b0);
    if (!is_trim_char(set_bytes[63:56])) push_word(set_bytes[63:56], 1'b0);
    push_word(trim_pick(), 1'b0);
    push_word(8'h00, 1'b1);
    random_words(RAND_WORDS);
    drain();

    // Held run exactly full, then past full, at full rate: overflow sticks from here on
    write_reg(REG_TRIM_CHARS, {$urandom, $urandom});
    write_reg(REG_TRIM_COUNT, CFG_DATA_W'(TRIM_SLOTS));
    @(negedge clk_i);
    no_gaps = 1'b1;
    push_word(plain_pick(), 1'b0);
    repeat (HELD_MAX) push_word(trim_pick(), 1'b0);
    push_word(plain_pick(), 1'b0);
    repeat (HELD_MAX + 3) push_word(trim_pick(), 1'b0);
    push_word(plain_pick(), 1'b0);
    push_word(8'h00, 1'b1);
    drain();
    no_gaps = 1'b0;
    random_words(RAND_WORDS);
    drain();

    if (errors == 0 && expected_out.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
